@@ src/cxu_pkg.sv @@
package cxu_pkg;

  // Default sizes
  localparam int MEM_WORDS_DEF = 65536;
  localparam int REG_COUNT_DEF = 32;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_TOP     = 1'b1;
  localparam logic [31:0] START_RESET = 32'd17;
  localparam logic [31:0] TOP_RESET   = 32'd32768;

  // Register indexes that read the stack pointer halves
  localparam logic [7:0] SP_LO_IDX = 8'd32;
  localparam logic [7:0] SP_HI_IDX = 8'd33;

  // Opcodes
  localparam logic [7:0] OP_SBCI  = 8'h07;
  localparam logic [7:0] OP_ANDI  = 8'h09;
  localparam logic [7:0] OP_ORI   = 8'h0B;
  localparam logic [7:0] OP_XORI  = 8'h0D;
  localparam logic [7:0] OP_NOT   = 8'h0E;
  localparam logic [7:0] OP_NEG   = 8'h0F;
  localparam logic [7:0] OP_SETB  = 8'h10;
  localparam logic [7:0] OP_CLRB  = 8'h11;
  localparam logic [7:0] OP_TST   = 8'h12;
  localparam logic [7:0] OP_CMP   = 8'h13;
  localparam logic [7:0] OP_CMPI  = 8'h14;
  localparam logic [7:0] OP_CLR   = 8'h15;
  localparam logic [7:0] OP_SER   = 8'h16;
  localparam logic [7:0] OP_MUL   = 8'h17;
  localparam logic [7:0] OP_MULS  = 8'h18;
  localparam logic [7:0] OP_MULSU = 8'h19;
  localparam logic [7:0] OP_LSL   = 8'h1A;
  localparam logic [7:0] OP_LSR   = 8'h1B;
  localparam logic [7:0] OP_ROL   = 8'h1C;
  localparam logic [7:0] OP_ROR   = 8'h1D;
  localparam logic [7:0] OP_ASR   = 8'h1E;
  localparam logic [7:0] OP_SWAP  = 8'h1F;
  localparam logic [7:0] OP_FSET  = 8'h20;
  localparam logic [7:0] OP_FCLR  = 8'h21;
  localparam logic [7:0] OP_BST   = 8'h22;
  localparam logic [7:0] OP_BLD   = 8'h23;
  localparam logic [7:0] OP_MOV   = 8'h24;
  localparam logic [7:0] OP_LDI   = 8'h25;
  localparam logic [7:0] OP_LD    = 8'h26;
  localparam logic [7:0] OP_ST    = 8'h27;
  localparam logic [7:0] OP_PUSH  = 8'h28;
  localparam logic [7:0] OP_POP   = 8'h29;
  localparam logic [7:0] OP_SOUT  = 8'h2C;
  localparam logic [7:0] OP_SOUTI = 8'h2D;
  localparam logic [7:0] OP_SIN   = 8'h2E;
  localparam logic [7:0] OP_RJMP  = 8'h2F;
  localparam logic [7:0] OP_JMP   = 8'h30;
  localparam logic [7:0] OP_CALL  = 8'h32;
  localparam logic [7:0] OP_CALLI = 8'h33;
  localparam logic [7:0] OP_RET   = 8'h34;
  localparam logic [7:0] OP_SKEQ  = 8'h35;
  localparam logic [7:0] OP_SKGE  = 8'h3A;
  localparam logic [7:0] OP_JEQI  = 8'h3B;
  localparam logic [7:0] OP_JGEI  = 8'h40;
  localparam logic [7:0] OP_JEQ   = 8'h41;
  localparam logic [7:0] OP_JGE   = 8'h46;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PAIR,
    ST_AGEN,
    ST_ACC,
    ST_LOAD,
    ST_MULHI
  } cxu_state_t;

  // Combinational ALU results of one instruction
  typedef struct packed {
    logic        wr_en;
    logic [7:0]  wr_idx;
    logic [15:0] wr_val;
    logic [15:0] mul_hi;
    logic [7:0]  flags;
    logic [31:0] next;
    logic        so_v;
    logic [7:0]  so_b;
    logic        unsup;
  } cxu_alu_out_t;

  // Branch and skip conditions: eq, ne, gt, le, ge, eq-or-not-gt
  function automatic logic cond_met(logic [2:0] cc, logic eq, logic gr);
    logic t;
    unique case (cc)
      3'd0:    t = eq;
      3'd1:    t = !eq;
      3'd2:    t = gr;
      3'd3:    t = !gr;
      3'd4:    t = eq || gr;
      3'd5:    t = eq || !gr;
      default: t = 1'b1;
    endcase
    return t;
  endfunction

endpackage

@@ src/cxu_if.sv @@
interface cxu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [7:0] field_a;
  logic [7:0] field_b;
  logic [7:0] field_c;
  logic       serial_ready;
  logic [7:0] serial_byte;

  modport source (output valid, command, field_a, field_b, field_c, serial_ready,
                  serial_byte, input ready);
  modport sink (input valid, command, field_a, field_b, field_c, serial_ready,
                serial_byte, output ready);
endinterface

interface cxu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_address;
  logic [7:0]  flag_bits;
  logic        serial_out_valid;
  logic [7:0]  serial_out_byte;
  logic        unsupported;

  modport source (output valid, next_address, flag_bits, serial_out_valid,
                  serial_out_byte, unsupported, input ready);
  modport sink (input valid, next_address, flag_bits, serial_out_valid,
                serial_out_byte, unsupported, output ready);
endinterface

@@ src/custom_16bit_cpu_execute_unit.sv @@
// Channel   Dir  Payload
// in_chan   in   command, field_a, field_b, field_c, serial_ready, serial_byte
// out_chan  out  next_address, flag_bits, serial_out_valid, serial_out_byte, unsupported
// cfg_*     in   write enable, register index, 32-bit data
//
// Register and flag instructions pass the register file read and the execute state, multiplies
// add a state for the high half; a new item is accepted only once the last one is finished.
// Stores, loads, push, pop, call and return add address and access states: each data
// memory access goes through a two-stage address reduction and the single memory port.
// Reset (rst_n low, synchronous) clears registers by valid bits at once; no clearing pass.
// A finished item waits in the output register; the next one is accepted only once it is taken.
module custom_16bit_cpu_execute_unit import cxu_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF,
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cxu_in_if.sink               in_chan,
  cxu_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int RAW = $clog2(REG_COUNT);
  localparam int MAW = $clog2(MEM_WORDS);

  cxu_state_t state_r, state_nxt;

  logic [7:0]  cmd_r, fa_r, fb_r, fc_r, sb_r;
  logic        rdy_r;
  logic [15:0] x_r, x_nxt, y_r, y_nxt, hi_r, hi_nxt, mulhi_r, mulhi_nxt;
  logic [31:0] next_r, next_nxt;
  logic        second_r, second_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [31:0] pc_r, sp_r, sp_nxt;
  logic [15:0] top_r;
  logic [REG_COUNT-1:0] valid_r;

  logic        out_valid_r;
  logic [31:0] out_next_r;
  logic [7:0]  out_flag_r, out_sob_r;
  logic        out_sov_r, out_unsup_r;

  logic           in_fire;
  logic           rf_re0, rf_re1, rf_we, rf_wreq;
  logic [RAW-1:0] rf_ra0, rf_ra1, rf_wa;
  logic [7:0]     rf_widx;
  logic [15:0]    rf_wval, rf_rd0, rf_rd1;
  logic           mem_we, mem_re;
  logic [15:0]    mem_wd, mem_rd;
  logic [MAW-1:0] mem_idx;
  logic [31:0]    mod_in;
  logic           fin;
  logic [31:0]    fin_next;
  logic [15:0]    xv, yv, cv;
  logic [31:0]    sp_view;
  logic [31:0]    ret_addr;
  logic           can_pop;
  cxu_alu_out_t   alu;

  // Register value with stack pointer halves and empty indexes
  function automatic logic [15:0] reg_value(logic [7:0] idx, logic [15:0] raw, logic vld,
                                            logic [31:0] sp);
    logic [15:0] v;
    priority if (idx < 8'(REG_COUNT)) begin
      v = vld ? raw : 16'h0;
    end else if (idx == SP_LO_IDX) begin
      v = sp[15:0];
    end else if (idx == SP_HI_IDX) begin
      v = sp[31:16];
    end else begin
      v = 16'h0;
    end
    return v;
  endfunction

  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);

  // A register call sees the stack pointer as it will be after both return words are pushed
  assign sp_view = (cmd_r == OP_CALL) ? (sp_r - 32'd2) : sp_r;

  assign xv = reg_value(fa_r, rf_rd0, valid_r[fa_r[RAW-1:0]], sp_view);
  assign yv = reg_value(fb_r, rf_rd1, valid_r[fb_r[RAW-1:0]], sp_view);
  assign cv = reg_value(fc_r, rf_rd0, valid_r[fc_r[RAW-1:0]], sp_r);

  assign ret_addr = pc_r + 32'd4;
  assign can_pop  = sp_r < {16'h0, top_r};

  cxu_regfile #(.COUNT(REG_COUNT), .AW(RAW)) u_regfile (
    .clk (clk),
    .re0 (rf_re0),
    .ra0 (rf_ra0),
    .rd0 (rf_rd0),
    .re1 (rf_re1),
    .ra1 (rf_ra1),
    .rd1 (rf_rd1),
    .we  (rf_we),
    .wa  (rf_wa),
    .wd  (rf_wval)
  );

  cxu_dmem #(.WORDS(MEM_WORDS), .AW(MAW)) u_dmem (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_idx),
    .wd   (mem_wd),
    .rd   (mem_rd)
  );

  cxu_amod #(.WORDS(MEM_WORDS), .AW(MAW)) u_amod (
    .clk  (clk),
    .addr (mod_in),
    .idx  (mem_idx)
  );

  cxu_alu u_alu (
    .command      (cmd_r),
    .field_a      (fa_r),
    .field_b      (fb_r),
    .field_c      (fc_r),
    .x            (xv),
    .y_reg        (yv),
    .flags        (flag_r),
    .pc           (pc_r),
    .serial_ready (rdy_r),
    .serial_byte  (sb_r),
    .res          (alu)
  );

  assign rf_we = rf_wreq && (rf_widx < 8'(REG_COUNT));
  assign rf_wa = rf_widx[RAW-1:0];

  // Sequence one instruction through register file, address unit and memory
  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    hi_nxt     = hi_r;
    mulhi_nxt  = mulhi_r;
    next_nxt   = next_r;
    second_nxt = second_r;
    flag_nxt   = flag_r;
    sp_nxt     = sp_r;
    rf_re0     = 1'b0;
    rf_re1     = 1'b0;
    rf_ra0     = in_chan.field_a[RAW-1:0];
    rf_ra1     = in_chan.field_b[RAW-1:0];
    rf_wreq    = 1'b0;
    rf_widx    = fa_r;
    rf_wval    = 16'h0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wd     = x_r;
    mod_in     = sp_r;
    fin        = 1'b0;
    fin_next   = next_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rf_re0    = 1'b1;
          rf_re1    = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        flag_nxt   = alu.flags;
        next_nxt   = alu.next;
        x_nxt      = xv;
        y_nxt      = yv;
        second_nxt = 1'b0;
        rf_wreq    = alu.wr_en;
        rf_widx    = alu.wr_idx;
        rf_wval    = alu.wr_val;
        mulhi_nxt  = alu.mul_hi;
        priority if (cmd_r >= OP_MUL && cmd_r <= OP_MULSU) begin
          state_nxt = ST_MULHI;
        end else if (cmd_r == OP_LD || cmd_r == OP_ST) begin
          // Fetch the high half of the address pair
          rf_re0    = 1'b1;
          rf_ra0    = fc_r[RAW-1:0];
          state_nxt = ST_PAIR;
        end else if (cmd_r == OP_PUSH) begin
          sp_nxt    = sp_r - 32'd1;
          state_nxt = ST_AGEN;
        end else if (cmd_r == OP_CALL || cmd_r == OP_CALLI) begin
          x_nxt     = ret_addr[15:0];
          hi_nxt    = ret_addr[31:16];
          sp_nxt    = sp_r - 32'd1;
          state_nxt = ST_AGEN;
        end else if (cmd_r == OP_POP || cmd_r == OP_RET) begin
          if (can_pop) begin
            mod_in    = sp_r + 32'd1;
            sp_nxt    = sp_r + 32'd1;
            state_nxt = ST_AGEN;
          end else begin
            // Empty stack gives zero
            rf_wreq   = cmd_r == OP_POP;
            rf_wval   = 16'h0;
            fin       = 1'b1;
            fin_next  = (cmd_r == OP_RET) ? 32'h0 : alu.next;
            state_nxt = ST_IDLE;
          end
        end else begin
          fin       = 1'b1;
          fin_next  = alu.next;
          state_nxt = ST_IDLE;
        end
      end
      ST_PAIR: begin
        mod_in    = {cv, y_r};
        state_nxt = ST_AGEN;
      end
      ST_AGEN: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        priority if (cmd_r == OP_ST || cmd_r == OP_PUSH) begin
          mem_we    = 1'b1;
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cmd_r == OP_CALL || cmd_r == OP_CALLI) begin
          mem_we = 1'b1;
          if (second_r) begin
            mem_wd    = hi_r;
            fin       = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            // Launch the push of the high half
            second_nxt = 1'b1;
            sp_nxt     = sp_r - 32'd1;
            state_nxt  = ST_AGEN;
          end
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (cmd_r == OP_RET) begin
          if (second_r) begin
            fin       = 1'b1;
            fin_next  = {hi_r, mem_rd};
            state_nxt = ST_IDLE;
          end else if (can_pop) begin
            hi_nxt     = mem_rd;
            second_nxt = 1'b1;
            mod_in     = sp_r + 32'd1;
            sp_nxt     = sp_r + 32'd1;
            state_nxt  = ST_AGEN;
          end else begin
            fin       = 1'b1;
            fin_next  = {mem_rd, 16'h0};
            state_nxt = ST_IDLE;
          end
        end else begin
          rf_wreq   = 1'b1;
          rf_wval   = mem_rd;
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MULHI: begin
        rf_wreq   = 1'b1;
        rf_widx   = 8'd1;
        rf_wval   = mulhi_r;
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state, architectural state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      second_r    <= 1'b0;
      flag_r      <= 8'h0;
      pc_r        <= START_RESET;
      sp_r        <= TOP_RESET;
      top_r       <= TOP_RESET[15:0];
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
      flag_r   <= flag_nxt;
      sp_r     <= sp_nxt;
      if (rf_we) begin
        valid_r[rf_wa] <= 1'b1;
      end
      if (fin) begin
        pc_r        <= fin_next;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_ADDRESS: pc_r <= cfg_wdata;
          CFG_STACK_TOP: begin
            top_r <= cfg_wdata[15:0];
            sp_r  <= {16'h0, cfg_wdata[15:0]};
          end
          default: top_r <= top_r;
        endcase
      end
    end
  end

  // Item fields, working values and the result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_chan.command;
      fa_r  <= in_chan.field_a;
      fb_r  <= in_chan.field_b;
      fc_r  <= in_chan.field_c;
      rdy_r <= in_chan.serial_ready;
      sb_r  <= in_chan.serial_byte;
    end
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    hi_r    <= hi_nxt;
    mulhi_r <= mulhi_nxt;
    next_r  <= next_nxt;
    if (fin) begin
      out_next_r  <= fin_next;
      out_flag_r  <= flag_nxt;
      out_sov_r   <= alu.so_v;
      out_sob_r   <= alu.so_b;
      out_unsup_r <= alu.unsup;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.next_address     = out_next_r;
  assign out_chan.flag_bits        = out_flag_r;
  assign out_chan.serial_out_valid = out_sov_r;
  assign out_chan.serial_out_byte  = out_sob_r;
  assign out_chan.unsupported      = out_unsup_r;

  // A result never overwrites one still waiting
  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (!out_valid_r || out_chan.ready))
    else $error("result overwrites a waiting item");

  // An accepted item goes straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted item not executed");

  // Program counter moves only at the end of an item or on configuration
  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!fin && !cfg_we) |=> $stable(pc_r))
    else $error("program counter changed mid item");

  // Memory is written only once its address is reduced
  a_mem_we: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_ACC))
    else $error("memory write outside access state");

endmodule

@@ src/cxu_regfile.sv @@
module cxu_regfile #(
  parameter int COUNT = 32,
  parameter int AW    = $clog2(COUNT)
) (
  input  logic          clk,
  input  logic          re0,
  input  logic [AW-1:0] ra0,
  output logic [15:0]   rd0,
  input  logic          re1,
  input  logic [AW-1:0] ra1,
  output logic [15:0]   rd1,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [15:0]   wd
);

  logic [15:0] mem [COUNT];

  // Write one word, read two with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re0) begin
      rd0 <= mem[ra0];
    end
    if (re1) begin
      rd1 <= mem[ra1];
    end
  end

endmodule

@@ src/cxu_dmem.sv @@
module cxu_dmem #(
  parameter int WORDS = 65536,
  parameter int AW    = $clog2(WORDS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [15:0]   wd,
  output logic [15:0]   rd
);

  logic [15:0] mem [WORDS];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    if (re) begin
      rd <= mem[addr];
    end
  end

endmodule

@@ src/cxu_amod.sv @@
module cxu_amod #(
  parameter int WORDS = 65536,
  parameter int AW    = $clog2(WORDS)
) (
  input  logic          clk,
  input  logic [31:0]   addr,
  output logic [AW-1:0] idx
);

  // Reciprocal estimate is at most one below the true quotient
  localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / WORDS);
  localparam logic [31:0] WORDS_W = 32'(WORDS);

  logic [31:0] a1_r;
  logic [32:0] q1_r;
  logic [31:0] r2_r;
  logic [64:0] prod;
  logic [65:0] qm;
  logic [31:0] r2_nxt;

  // Stage one: quotient estimate
  assign prod = 65'(addr) * 65'(RECIP);
  // Stage two: remainder below twice the size
  assign qm     = 66'(q1_r) * 66'(WORDS_W);
  assign r2_nxt = a1_r - qm[31:0];

  always_ff @(posedge clk) begin
    a1_r <= addr;
    q1_r <= prod[64:32];
    r2_r <= r2_nxt;
  end

  // Final correction
  always_comb begin
    logic [31:0] r;
    r   = (r2_r >= WORDS_W) ? (r2_r - WORDS_W) : r2_r;
    idx = r[AW-1:0];
  end

endmodule

@@ src/cxu_alu.sv @@
module cxu_alu import cxu_pkg::*; (
  input  logic [7:0]   command,
  input  logic [7:0]   field_a,
  input  logic [7:0]   field_b,
  input  logic [7:0]   field_c,
  input  logic [15:0]  x,
  input  logic [15:0]  y_reg,
  input  logic [7:0]   flags,
  input  logic [31:0]  pc,
  input  logic         serial_ready,
  input  logic [7:0]   serial_byte,
  output cxu_alu_out_t res
);

  always_comb begin
    logic [15:0] imm16;
    logic [23:0] imm24;
    logic [15:0] y;
    logic        ci;
    logic [16:0] sum;
    logic [31:0] xe;
    logic [31:0] ye;
    logic [31:0] prod;
    logic [31:0] seq;
    logic [31:0] tgt;
    logic        take;
    logic        eq;
    logic        gr;

    imm16 = {field_c, field_b};
    imm24 = {field_c, field_b, field_a};
    eq    = flags[1];
    gr    = flags[2];
    seq   = pc + 32'd4;
    y     = 16'h0;
    ci    = 1'b0;
    sum   = 17'h0;
    xe    = 32'h0;
    ye    = 32'h0;
    prod  = 32'h0;
    tgt   = 32'h0;
    take  = 1'b1;

    res        = '0;
    res.wr_idx = field_a;
    res.flags  = flags;
    res.next   = seq;

    priority if (command <= OP_SBCI) begin
      // Add and subtract with true carry and borrow
      y  = command[1] ? imm16 : y_reg;
      ci = command[0] & flags[0];
      res.wr_en = 1'b1;
      if (command[2]) begin
        sum = 17'(y) + 17'(ci);
        res.flags[0] = sum > 17'(x);
        res.wr_val = x - y - 16'(ci);
      end else begin
        sum = 17'(x) + 17'(y) + 17'(ci);
        res.flags[0] = sum[16];
        res.wr_val = sum[15:0];
      end
    end else if (command <= OP_XORI) begin
      y = command[0] ? imm16 : y_reg;
      res.wr_en = 1'b1;
      if (command <= OP_ANDI) begin
        res.wr_val = x & y;
      end else if (command <= OP_ORI) begin
        res.wr_val = x | y;
      end else begin
        res.wr_val = x ^ y;
      end
    end else if (command == OP_NOT || command == OP_NEG) begin
      res.wr_en  = 1'b1;
      res.wr_val = ~x + ((command == OP_NEG) ? 16'd1 : 16'd0);
    end else if (command == OP_SETB) begin
      res.wr_en  = 1'b1;
      res.wr_val = x | imm16;
    end else if (command == OP_CLRB) begin
      res.wr_en  = 1'b1;
      res.wr_val = x & ~imm16;
    end else if (command >= OP_TST && command <= OP_CMPI) begin
      // Compare against zero, register or immediate
      y = (command == OP_TST) ? 16'h0 : ((command == OP_CMP) ? y_reg : imm16);
      res.flags[1] = x == y;
      res.flags[2] = x > y;
    end else if (command == OP_CLR || command == OP_SER) begin
      res.wr_en  = 1'b1;
      res.wr_val = (command == OP_CLR) ? 16'h0000 : 16'hFFFF;
    end else if (command >= OP_MUL && command <= OP_MULSU) begin
      // Product low half to register 0, high half to register 1
      xe = (command == OP_MUL) ? {16'h0, x} : {{16{x[15]}}, x};
      ye = (command == OP_MULS) ? {{16{y_reg[15]}}, y_reg} : {16'h0, y_reg};
      prod = xe * ye;
      res.wr_en  = 1'b1;
      res.wr_idx = 8'd0;
      res.wr_val = prod[15:0];
      res.mul_hi = prod[31:16];
    end else if (command == OP_LSL || command == OP_ROL) begin
      res.flags[0] = x[15];
      res.wr_en  = 1'b1;
      res.wr_val = {x[14:0], (command == OP_ROL) & flags[0]};
    end else if (command == OP_LSR || command == OP_ROR || command == OP_ASR) begin
      res.flags[0] = x[0];
      res.wr_en  = 1'b1;
      if (command == OP_ASR) begin
        res.wr_val = {x[15], x[15:1]};
      end else begin
        res.wr_val = {(command == OP_ROR) & flags[0], x[15:1]};
      end
    end else if (command == OP_SWAP) begin
      res.wr_en  = 1'b1;
      res.wr_val = {x[15:8], x[3:0], x[7:4]};
    end else if (command == OP_FSET || command == OP_FCLR) begin
      if (field_a <= 8'd7) begin
        res.flags[field_a[2:0]] = command == OP_FSET;
      end
    end else if (command == OP_BST) begin
      if (field_b < 8'd16) begin
        res.flags[3] = x[field_b[3:0]];
      end
    end else if (command == OP_BLD) begin
      if (field_b < 8'd16) begin
        res.wr_en  = 1'b1;
        res.wr_val = x;
        res.wr_val[field_b[3:0]] = flags[3];
      end
    end else if (command == OP_MOV || command == OP_LDI) begin
      res.wr_en  = 1'b1;
      res.wr_val = (command == OP_MOV) ? y_reg : imm16;
    end else if (command >= OP_LD && command <= OP_POP) begin
      // Memory and stack access run in the sequencer
      res.wr_en = 1'b0;
    end else if (command == OP_SOUT || command == OP_SOUTI) begin
      res.so_v = 1'b1;
      res.so_b = (command == OP_SOUT) ? x[7:0] : field_a;
    end else if (command == OP_SIN) begin
      res.wr_en  = 1'b1;
      res.wr_val = serial_ready ? {8'h0, serial_byte} : 16'hFFFF;
    end else if (command == OP_RJMP) begin
      res.next = seq + {{6{field_c[7]}}, imm24, 2'b00};
    end else if ((command >= OP_JMP && command <= OP_CALLI) ||
                 (command >= OP_JEQI && command <= OP_JGE)) begin
      // Absolute jumps, calls and conditional jumps
      if (command >= OP_JEQ) begin
        take = cond_met(3'(command - OP_JEQ), eq, gr);
      end else if (command >= OP_JEQI) begin
        take = cond_met(3'(command - OP_JEQI), eq, gr);
      end
      if (command == OP_JMP || command == OP_CALL || command >= OP_JEQ) begin
        tgt = {y_reg, x};
      end else begin
        tgt = {8'h0, imm24};
      end
      if (take) begin
        res.next = {tgt[29:0], 2'b00};
      end
    end else if (command == OP_RET) begin
      res.wr_en = 1'b0;
    end else if (command >= OP_SKEQ && command <= OP_SKGE) begin
      if (cond_met(3'(command - OP_SKEQ), eq, gr)) begin
        res.next = seq + 32'd4;
      end
    end else begin
      res.unsup = 1'b1;
    end
  end

endmodule
